@@ rtl/framed_log_ring_buffer_core_macros.svh @@
// Assertion macros shared by the ring buffer RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef FRAMED_LOG_RING_BUFFER_CORE_MACROS_SVH
`define FRAMED_LOG_RING_BUFFER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define FLRB_ASSERT_IMP(lbl, clock, reset, ante, cons, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define FLRB_ASSERT_NXT(lbl, clock, reset, ante, cons, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/flrb_pkg.sv @@
// Types and fixed codes for the framed log ring buffer.
// No dependencies; used by the core by scoped names.
package flrb_pkg;

  // Request types
  localparam logic [2:0] REQ_OPEN    = 3'd0;
  localparam logic [2:0] REQ_BYTE    = 3'd1;
  localparam logic [2:0] REQ_PEEK    = 3'd2;
  localparam logic [2:0] REQ_CONSUME = 3'd3;
  localparam logic [2:0] REQ_CLEAR   = 3'd4;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_DISABLED  = 3'd1;
  localparam logic [2:0] ST_TOO_LARGE = 3'd2;
  localparam logic [2:0] ST_NO_ROOM   = 3'd3;
  localparam logic [2:0] ST_OFFSET    = 3'd4;

  // Register index of logger_enabled
  localparam logic CFG_IDX_ENABLE = 1'b0;

  // Bytes in the little-endian length header
  localparam int unsigned LEN_FIELD = 2;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [8:0]  record_length;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [9:0]  peek_offset;
    logic [15:0] consume_count;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] read_value;
    logic [9:0] used_count;
    logic [9:0] space_count;
  } rsp_t;

endpackage

@@ rtl/flrb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the byte ring of the core.
module flrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/framed_log_ring_buffer_core.sv @@
// Framed log ring buffer: a byte ring of DEPTH entries holding framed records.
// Peek, consume, clear, a refused open and a byte go from idle straight to the result
// state; a closing byte with padding first writes its pad bytes (up to 3). An accepted open
// checks for room, drops the oldest records one by one (emptying a short ring at once),
// then writes the header. One request at a time; the result register frees the input.
// Reset: synchronous, clears pointers, open record, padding and logger_enabled.
module framed_log_ring_buffer_core #(
  parameter int DEPTH      = 1024,
  parameter int MAX_RECORD = 256,
  parameter int MAX_DROPS  = 10
) (
  input  logic           clk,
  input  logic           rst,
  // request channel
  input  logic           req_valid,
  output logic           req_stall,
  input  flrb_pkg::req_t req,
  // result channel
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output flrb_pkg::rsp_t rsp,
  // configuration port
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  `include "framed_log_ring_buffer_core_macros.svh"

  localparam int PW = $clog2(DEPTH);
  localparam int SW = ((PW > 10) ? PW : 10) + 1;
  localparam int DW = $clog2(MAX_DROPS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_OCHK = 3'd1;
  localparam logic [2:0] S_DRD0 = 3'd2;
  localparam logic [2:0] S_DRD1 = 3'd3;
  localparam logic [2:0] S_HDR0 = 3'd4;
  localparam logic [2:0] S_HDR1 = 3'd5;
  localparam logic [2:0] S_PAD  = 3'd6;
  localparam logic [2:0] S_RESP = 3'd7;

  logic [2:0]    state, state_next;
  logic [PW-1:0] wp, wp_next, rp, rp_next;
  logic [1:0]    pad_pending, pad_pending_next;
  logic          record_open, record_open_next;
  logic          logger_enabled;

  logic [8:0]    rec_len, rec_len_next;
  logic [9:0]    padded, padded_next;
  logic [DW-1:0] drops, drops_next;
  logic [7:0]    len_lo, len_lo_next;
  logic [2:0]    status, status_next;
  logic          peek_ok, peek_ok_next;

  logic          ram_we, ram_re;
  logic [PW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  logic [PW-1:0] used, space;
  logic [PW-1:0] wp_inc, rp_inc;
  logic          push_en;
  logic [7:0]    push_data;

  logic          accept;
  logic [9:0]    open_sum;
  logic [9:0]    open_padded;
  logic [SW-1:0] peek_sum;
  logic [PW-1:0] peek_addr;
  logic [PW-1:0] consume_n;
  logic [15:0]   drop_len;
  logic [17:0]   drop_padded;

  function automatic logic [PW-1:0] wrap_add(logic [PW:0] s);
    logic [PW:0] r;
    r = (s >= (PW+1)'(DEPTH)) ? (s - (PW+1)'(DEPTH)) : s;
    return r[PW-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == flrb_pkg::CFG_IDX_ENABLE) ? {31'd0, logger_enabled} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      logger_enabled <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == flrb_pkg::CFG_IDX_ENABLE) begin
      logger_enabled <= pwdata[0];
    end
  end

  // ---------------------------------------------------------------------------
  // Ring arithmetic
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [PW:0] u;
    u = {1'b0, wp} + ((wp < rp) ? (PW+1)'(DEPTH) : (PW+1)'(0)) - {1'b0, rp};
    used  = u[PW-1:0];
    space = PW'(DEPTH - 1) - used;
  end

  assign wp_inc = wrap_add({1'b0, wp} + (PW+1)'(1));
  assign rp_inc = wrap_add({1'b0, rp} + (PW+1)'(1));

  assign accept = req_valid && !req_stall;

  // padded size of the record being opened
  assign open_sum    = 10'(req.record_length) + 10'(flrb_pkg::LEN_FIELD) + 10'd3;
  assign open_padded = open_sum & ~10'd3;

  always_comb begin
    logic [SW-1:0] r;
    peek_sum  = SW'(rp) + SW'(req.peek_offset);
    r         = (peek_sum >= SW'(DEPTH)) ? (peek_sum - SW'(DEPTH)) : peek_sum;
    peek_addr = r[PW-1:0];
  end

  assign consume_n = (17'(req.consume_count) > 17'(used)) ? used
                                                           : req.consume_count[PW-1:0];

  assign drop_len    = {ram_rdata, len_lo};
  assign drop_padded = (18'(drop_len) + 18'(flrb_pkg::LEN_FIELD) + 18'd3) & ~18'd3;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next       = state;
    wp_next          = wp;
    rp_next          = rp;
    pad_pending_next = pad_pending;
    record_open_next = record_open;
    rec_len_next     = rec_len;
    padded_next      = padded;
    drops_next       = drops;
    len_lo_next      = len_lo;
    status_next      = status;
    peek_ok_next     = peek_ok;
    push_en          = 1'b0;
    push_data        = 8'd0;
    ram_re           = 1'b0;
    ram_raddr        = rp;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          status_next  = flrb_pkg::ST_OK;
          peek_ok_next = 1'b0;
          state_next   = S_RESP;
          unique case (req.req_type)
            flrb_pkg::REQ_OPEN: begin
              if (!logger_enabled) begin
                status_next = flrb_pkg::ST_DISABLED;
              end else if (req.record_length == 9'd0 ||
                           13'(req.record_length) > 13'(MAX_RECORD) ||
                           17'(open_padded) >= 17'(DEPTH)) begin
                status_next = flrb_pkg::ST_TOO_LARGE;
              end else begin
                rec_len_next = req.record_length;
                padded_next  = open_padded;
                drops_next   = '0;
                state_next   = S_OCHK;
              end
            end
            flrb_pkg::REQ_BYTE: begin
              if (record_open) begin
                push_en   = 1'b1;
                push_data = req.data_byte;
                if (req.last_byte) begin
                  if (pad_pending == 2'd0) begin
                    record_open_next = 1'b0;
                  end else begin
                    state_next = S_PAD;
                  end
                end
              end
            end
            flrb_pkg::REQ_PEEK: begin
              if (17'(req.peek_offset) >= 17'(used)) begin
                status_next = flrb_pkg::ST_OFFSET;
              end else begin
                ram_re       = 1'b1;
                ram_raddr    = peek_addr;
                peek_ok_next = 1'b1;
              end
            end
            flrb_pkg::REQ_CONSUME: begin
              rp_next = wrap_add({1'b0, rp} + {1'b0, consume_n});
            end
            flrb_pkg::REQ_CLEAR: begin
              wp_next          = '0;
              rp_next          = '0;
              pad_pending_next = 2'd0;
              record_open_next = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      S_OCHK: begin
        if (17'(space) >= 17'(padded)) begin
          state_next = S_HDR0;
        end else if (drops == DW'(MAX_DROPS)) begin
          status_next = flrb_pkg::ST_NO_ROOM;
          state_next  = S_RESP;
        end else if (17'(used) < 17'(flrb_pkg::LEN_FIELD)) begin
          // no room for a length header: empty the ring
          wp_next    = '0;
          rp_next    = '0;
          drops_next = drops + DW'(1);
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = rp;
          state_next = S_DRD0;
        end
      end

      S_DRD0: begin
        len_lo_next = ram_rdata;
        ram_re      = 1'b1;
        ram_raddr   = rp_inc;
        state_next  = S_DRD1;
      end

      S_DRD1: begin
        // drop the oldest record, or clear the ring on a bad header
        if (drop_len == 16'd0 || 17'(drop_len) > 17'(MAX_RECORD) ||
            drop_padded > 18'(used)) begin
          wp_next = '0;
          rp_next = '0;
        end else begin
          rp_next = wrap_add({1'b0, rp} + {1'b0, drop_padded[PW-1:0]});
        end
        drops_next = drops + DW'(1);
        state_next = S_OCHK;
      end

      S_HDR0: begin
        push_en    = 1'b1;
        push_data  = rec_len[7:0];
        state_next = S_HDR1;
      end

      S_HDR1: begin
        push_en          = 1'b1;
        push_data        = {7'd0, rec_len[8]};
        pad_pending_next = 2'(padded - (10'(rec_len) + 10'(flrb_pkg::LEN_FIELD)));
        record_open_next = 1'b1;
        status_next      = flrb_pkg::ST_OK;
        state_next       = S_RESP;
      end

      S_PAD: begin
        push_en          = 1'b1;
        push_data        = 8'd0;
        pad_pending_next = pad_pending - 2'd1;
        if (pad_pending == 2'd1) begin
          record_open_next = 1'b0;
          state_next       = S_RESP;
        end
      end

      S_RESP: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // at most one byte pushed per cycle; a full ring loses its oldest byte
    if (push_en) begin
      wp_next = wp_inc;
      if (wp_inc == rp) begin
        rp_next = rp_inc;
      end
    end
  end

  assign ram_we    = push_en;
  assign ram_waddr = wp;
  assign ram_wdata = push_data;

  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      wp          <= '0;
      rp          <= '0;
      pad_pending <= 2'd0;
      record_open <= 1'b0;
      drops       <= '0;
    end else begin
      state       <= state_next;
      wp          <= wp_next;
      rp          <= rp_next;
      pad_pending <= pad_pending_next;
      record_open <= record_open_next;
      drops       <= drops_next;
    end
  end

  always_ff @(posedge clk) begin
    rec_len <= rec_len_next;
    padded  <= padded_next;
    len_lo  <= len_lo_next;
    status  <= status_next;
    peek_ok <= peek_ok_next;
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_RESP && (!rsp_valid || !rsp_stall)) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESP && (!rsp_valid || !rsp_stall)) begin
      rsp.status      <= status;
      rsp.read_value  <= peek_ok ? ram_rdata : 8'd0;
      rsp.used_count  <= 10'(used);
      rsp.space_count <= 10'(space);
    end
  end

  flrb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `FLRB_ASSERT_IMP(a_ptr_range, clk, rst, 1'b1,
    (32'(wp) < DEPTH) && (32'(rp) < DEPTH), "ring pointer beyond DEPTH")
  `FLRB_ASSERT_IMP(a_pad_closed, clk, rst, !record_open,
    pad_pending == 2'd0, "padding pending without an open record")
  `FLRB_ASSERT_IMP(a_drop_bound, clk, rst, state == S_DRD0 || state == S_DRD1,
    32'(drops) < MAX_DROPS, "drop walk beyond its limit")
  `FLRB_ASSERT_NXT(a_accept_busy, clk, rst, accept,
    state != S_IDLE, "accepted request left the sequencer idle")
  `FLRB_ASSERT_IMP(a_hdr_order, clk, rst, state == S_DRD1,
    $past(state) == S_DRD0, "length high byte read out of order")

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for framed_log_ring_buffer_core: directed and random requests are
// scored against a byte-ring model kept inside the bench. Needs flrb_pkg and the core RTL.
module tb;

  localparam int unsigned RING_DEPTH  = 1024;
  localparam int unsigned MAX_REC     = 256;
  localparam int unsigned MAX_DROP    = 10;
  localparam int unsigned SETTLE      = 4 + 3 * MAX_DROP + 8;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic           clk;
  logic           rst;
  logic           req_valid;
  logic           req_stall;
  flrb_pkg::req_t req;
  logic           rsp_valid;
  logic           rsp_stall;
  flrb_pkg::rsp_t rsp;
  logic           psel;
  logic           penable;
  logic           pwrite;
  logic [2:0]     paddr;
  logic [31:0]    pwdata;
  logic [31:0]    prdata;
  logic           pready;

  // ring model
  logic [7:0]  ring_mem [RING_DEPTH];
  int unsigned ring_wr;
  int unsigned ring_rd;
  int unsigned pad_left;
  bit          rec_open;
  bit          log_en;

  flrb_pkg::rsp_t rsp_due [$];
  flrb_pkg::rsp_t want_rsp;
  int unsigned items_sent    = 0;
  int unsigned fail_count    = 0;
  int unsigned cycles        = 0;
  int unsigned send_idle_pct = 7;
  int unsigned recv_idle_pct = 84;
  int          hold_left     = 0;

  framed_log_ring_buffer_core #(
    .DEPTH(RING_DEPTH),
    .MAX_RECORD(MAX_REC),
    .MAX_DROPS(MAX_DROP)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Receiver: random stalls, or a counted hold-off when one is asked for
  always @(posedge clk) begin
    if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left--;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (rsp_due.size() == 0) begin
        $error("result with no request outstanding: status %0d, used %0d",
               rsp.status, rsp.used_count);
        fail_count++;
      end else begin
        want_rsp = rsp_due.pop_front();
        check_field("status", want_rsp.status, rsp.status);
        check_field("read_value", want_rsp.read_value, rsp.read_value);
        check_field("used_count", want_rsp.used_count, rsp.used_count);
        check_field("space_count", want_rsp.space_count, rsp.space_count);
      end
    end
  end

  // ---------------------------------------------------------------- ring model

  function automatic int unsigned ring_used();
    return (ring_wr >= ring_rd) ? ring_wr - ring_rd : RING_DEPTH - ring_rd + ring_wr;
  endfunction

  function automatic int unsigned ring_free();
    return RING_DEPTH - 1 - ring_used();
  endfunction

  // A push into a full ring overwrites the oldest byte
  function automatic void ring_push(input logic [7:0] value);
    ring_mem[ring_wr] = value;
    ring_wr = (ring_wr + 1) % RING_DEPTH;
    if (ring_wr == ring_rd)
      ring_rd = (ring_rd + 1) % RING_DEPTH;
  endfunction

  function automatic logic [7:0] ring_byte(input int unsigned ofs);
    return ring_mem[(ring_rd + ofs) % RING_DEPTH];
  endfunction

  function automatic void ring_pop(input int unsigned n);
    int unsigned u;
    u = ring_used();
    if (n > u)
      n = u;
    ring_rd = (ring_rd + n) % RING_DEPTH;
  endfunction

  function automatic void ring_empty();
    ring_wr = 0;
    ring_rd = 0;
  endfunction

  // Drop the oldest record; a short, zero, oversized or truncated length empties the ring
  function automatic void ring_drop_oldest();
    int unsigned u;
    int unsigned len;
    int unsigned padded;
    u = ring_used();
    if (u < flrb_pkg::LEN_FIELD) begin
      ring_empty();
      return;
    end
    len = {ring_byte(1), ring_byte(0)};
    if (len == 0 || len > MAX_REC) begin
      ring_empty();
      return;
    end
    padded = (flrb_pkg::LEN_FIELD + len + 3) & ~32'd3;
    if (padded > u) begin
      ring_empty();
      return;
    end
    ring_pop(padded);
  endfunction

  function automatic logic [2:0] ring_open(input int unsigned len);
    int unsigned entry;
    int unsigned padded;
    if (!log_en)
      return flrb_pkg::ST_DISABLED;
    if (len == 0 || len > MAX_REC)
      return flrb_pkg::ST_TOO_LARGE;
    entry  = flrb_pkg::LEN_FIELD + len;
    padded = (entry + 3) & ~32'd3;
    if (padded >= RING_DEPTH)
      return flrb_pkg::ST_TOO_LARGE;
    for (int i = 0; i < MAX_DROP && ring_free() < padded; i++)
      ring_drop_oldest();
    if (ring_free() < padded)
      return flrb_pkg::ST_NO_ROOM;
    ring_push(len[7:0]);
    ring_push(len[15:8]);
    pad_left = padded - entry;
    rec_open = 1'b1;
    return flrb_pkg::ST_OK;
  endfunction

  function automatic flrb_pkg::rsp_t apply_request(input flrb_pkg::req_t r);
    flrb_pkg::rsp_t res;
    res = '0;
    case (r.req_type)
      flrb_pkg::REQ_OPEN: res.status = ring_open(r.record_length);
      flrb_pkg::REQ_BYTE: begin
        if (rec_open) begin
          ring_push(r.data_byte);
          if (r.last_byte) begin
            repeat (pad_left) ring_push(8'h00);
            pad_left = 0;
            rec_open = 1'b0;
          end
        end
      end
      flrb_pkg::REQ_PEEK: begin
        if (r.peek_offset >= ring_used())
          res.status = flrb_pkg::ST_OFFSET;
        else
          res.read_value = ring_byte(r.peek_offset);
      end
      flrb_pkg::REQ_CONSUME: ring_pop(r.consume_count);
      flrb_pkg::REQ_CLEAR: begin
        ring_empty();
        pad_left = 0;
        rec_open = 1'b0;
      end
      default: ;
    endcase
    res.used_count  = 10'(ring_used());
    res.space_count = 10'(ring_free());
    return res;
  endfunction

  // ---------------------------------------------------------------- drivers

  function automatic flrb_pkg::req_t make_req(input logic [2:0] kind);
    flrb_pkg::req_t r;
    logic [63:0]    bits;
    bits = {$urandom(), $urandom()};
    r = bits[$bits(flrb_pkg::req_t)-1:0];
    r.req_type = kind;
    return r;
  endfunction

  // Offer one request and hold it until accepted; valid stays high for the next one
  task automatic send_req(input flrb_pkg::req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (req_stall !== 1'b0) @(posedge clk);
    rsp_due.push_back(apply_request(r));
    items_sent++;
  endtask

  task automatic send_record(input int unsigned len, input int unsigned n_bytes,
                             input bit close);
    flrb_pkg::req_t r;
    r = make_req(flrb_pkg::REQ_OPEN);
    r.record_length = 9'(len);
    send_req(r);
    for (int unsigned i = 0; i < n_bytes; i++) begin
      r = make_req(flrb_pkg::REQ_BYTE);
      r.last_byte = close && (i == n_bytes - 1);
      send_req(r);
    end
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (rsp_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_logger_enable(input bit value);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * flrb_pkg::CFG_IDX_ENABLE);
    pwdata  <= ($urandom() & ~32'h1) | 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    log_en = value;
  endtask

  function automatic int unsigned pick_length();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 70)
      return $urandom_range(8, 1);
    if (p < 90)
      return $urandom_range(48, 9);
    if (p < 97)
      return $urandom_range(MAX_REC, 49);
    if (p < 98)
      return 0;
    return $urandom_range(511, MAX_REC + 1);
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_reset_state();
    flrb_pkg::req_t r;
    r = make_req(flrb_pkg::REQ_OPEN);
    r.record_length = 9'd5;
    send_req(r);
    r = make_req(flrb_pkg::REQ_BYTE);
    send_req(r);
    r = make_req(flrb_pkg::REQ_PEEK);
    r.peek_offset = '0;
    send_req(r);
    r = make_req(flrb_pkg::REQ_CONSUME);
    r.consume_count = 16'hFFFF;
    send_req(r);
    // spare request codes above clear
    for (int k = 1; k <= 3; k++) begin
      r = make_req(flrb_pkg::REQ_CLEAR + 3'(k));
      send_req(r);
    end
  endtask

  task automatic test_record_framing();
    flrb_pkg::req_t r;
    write_logger_enable(1'b1);
    r = make_req(flrb_pkg::REQ_OPEN);
    r.record_length = 9'd0;
    send_req(r);
    r = make_req(flrb_pkg::REQ_OPEN);
    r.record_length = 9'(MAX_REC + 1);
    send_req(r);
    r = make_req(flrb_pkg::REQ_OPEN);
    r.record_length = 9'h1FF;
    send_req(r);
    // smallest record: one pad byte
    r = make_req(flrb_pkg::REQ_OPEN);
    r.record_length = 9'd1;
    send_req(r);
    r = make_req(flrb_pkg::REQ_BYTE);
    r.data_byte = 8'hFF;
    r.last_byte = 1'b1;
    send_req(r);
    // largest record left unfinished, then superseded by a fresh open
    r = make_req(flrb_pkg::REQ_OPEN);
    r.record_length = 9'(MAX_REC);
    send_req(r);
    r = make_req(flrb_pkg::REQ_BYTE);
    r.data_byte = 8'h00;
    r.last_byte = 1'b0;
    send_req(r);
    send_record(3, 3, 1'b1);
    r = make_req(flrb_pkg::REQ_PEEK);
    r.peek_offset = '0;
    send_req(r);
    r = make_req(flrb_pkg::REQ_PEEK);
    r.peek_offset = 10'h3FF;
    send_req(r);
    r = make_req(flrb_pkg::REQ_CONSUME);
    r.consume_count = '0;
    send_req(r);
    r = make_req(flrb_pkg::REQ_CLEAR);
    send_req(r);
  endtask

  // The enable gates opens only: bytes of an open record still land
  task automatic test_disable_gating();
    flrb_pkg::req_t r;
    send_record(4, 1, 1'b0);
    write_logger_enable(1'b0);
    for (int i = 0; i < 3; i++) begin
      r = make_req(flrb_pkg::REQ_BYTE);
      r.last_byte = (i == 2);
      send_req(r);
    end
    r = make_req(flrb_pkg::REQ_OPEN);
    r.record_length = 9'd8;
    send_req(r);
    write_logger_enable(1'b1);
  endtask

  task automatic test_mixed_traffic(input int unsigned n);
    int unsigned    stop_at;
    int unsigned    p;
    int unsigned    len;
    int unsigned    u;
    flrb_pkg::req_t r;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      p = $urandom_range(99);
      if (p < 45) begin
        len = pick_length();
        if (len == 0 || len > MAX_REC)
          send_record(len, 0, 1'b0);
        else
          send_record(len, len, 1'b1);
      end else if (p < 50) begin
        // overrun: more bytes than declared
        len = $urandom_range(40, 1);
        send_record(len, len + $urandom_range(20, 1), 1'b1);
      end else if (p < 55) begin
        len = $urandom_range(40, 2);
        send_record(len, $urandom_range(len - 1), 1'b1);
      end else if (p < 60) begin
        // leave the record open for whatever follows
        len = $urandom_range(40, 1);
        send_record(len, $urandom_range(len), 1'b0);
      end else if (p < 72) begin
        u = ring_used();
        r = make_req(flrb_pkg::REQ_PEEK);
        if (u > 0 && $urandom_range(4) != 0)
          r.peek_offset = 10'($urandom_range(u - 1));
        send_req(r);
      end else if (p < 80) begin
        r = make_req(flrb_pkg::REQ_CONSUME);
        case ($urandom_range(2))
          0: r.consume_count = 16'($urandom_range(8));
          1: r.consume_count = 16'($urandom_range(ring_used()));
          default: ;
        endcase
        send_req(r);
      end else if (p < 82) begin
        r = make_req(flrb_pkg::REQ_CLEAR);
        send_req(r);
      end else if (p < 88) begin
        r = make_req(flrb_pkg::REQ_BYTE);
        send_req(r);
      end else begin
        r = make_req(3'($urandom_range(7)));
        send_req(r);
      end
    end
  endtask

  // Pack the ring with tiny records so that ten drops cannot free a large one
  task automatic test_fill_and_evict();
    flrb_pkg::req_t r;
    int unsigned    len;
    r = make_req(flrb_pkg::REQ_CLEAR);
    send_req(r);
    while (ring_free() >= 4) begin
      len = ($urandom_range(6) == 0) ? 2 : 1;
      send_record(len, len, 1'b1);
    end
    r = make_req(flrb_pkg::REQ_OPEN);
    r.record_length = 9'(MAX_REC);
    send_req(r);
    send_record(30, 30 + $urandom_range(80, 40), 1'b1);
    // misalign the tail, then force drops over it
    r = make_req(flrb_pkg::REQ_CONSUME);
    r.consume_count = 16'd1;
    send_req(r);
    r = make_req(flrb_pkg::REQ_OPEN);
    r.record_length = 9'd200;
    send_req(r);
  endtask

  task automatic test_backpressure();
    hold_left = 250;
    send_record(12, 12, 1'b1);
    wait_drained();
  endtask

  initial begin
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    rsp_stall <= 1'b0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    ring_wr  = 0;
    ring_rd  = 0;
    pad_left = 0;
    rec_open = 1'b0;
    log_en   = 1'b0;
    for (int i = 0; i < RING_DEPTH; i++)
      ring_mem[i] = 8'h00;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 7;
    recv_idle_pct = 84;
    test_reset_state();
    test_record_framing();
    test_disable_gating();
    test_mixed_traffic(70);
    write_logger_enable(1'b0);
    test_mixed_traffic(25);
    write_logger_enable(1'b1);

    send_idle_pct = 84;
    recv_idle_pct = 7;
    test_fill_and_evict();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_mixed_traffic(60);

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/flrb_pkg.sv
rtl/flrb_ram.sv
rtl/framed_log_ring_buffer_core.sv
bench/tb.sv
